@@ design/ubrtq_pkg.sv @@
package ubrtq_pkg;

  // Default ring depths
  localparam int unsigned RxDepthDef = 64;
  localparam int unsigned TxDepthDef = 64;

  // Fixed field widths
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ErrW   = 4;
  localparam int unsigned LenW   = 7;
  localparam int unsigned MaskW  = 5;
  localparam int unsigned FillW  = 7;
  localparam int unsigned FlagW  = 5;

  // Sticky flag positions
  localparam int unsigned FlagBufFull = 4;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_LINE_BYTE = 3'd0,
    CMD_APP_READ  = 3'd1,
    CMD_SEND_BYTE = 3'd2,
    CMD_TX_READY  = 3'd3,
    CMD_TX_DONE   = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_e;

  // Send burst tracking, one-hot
  typedef enum logic [3:0] {
    BS_IDLE   = 4'b0001,
    BS_FILL   = 4'b0010,
    BS_REJECT = 4'b0100,
    BS_SKIP   = 4'b1000
  } burst_e;

  // Result fields that do not come from a ring memory
  typedef struct packed {
    logic             rx_valid;
    logic             tx_valid;
    logic             accepted;
    logic             busy;
    logic             done;
    logic [FillW-1:0] fill;
    logic [FlagW-1:0] flags;
  } res_t;

endpackage

@@ design/uart_buffered_rx_tx_queues.sv @@
// Buffered serial-port queues: a receive ring and a transmit ring.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// line byte, application read, send byte, transmit ready, transmit complete or
// clear flags. Output channel (out_valid_o / out_stall_i) returns exactly one
// result transaction per command, in order.
// The accepting edge updates pointers and counters, reads the ring memory and
// writes the pending stage; the result then moves with the registered read
// data into the output register, from which it is offered.
// Throughput: one command per cycle while the output side keeps up; the limit
// is the single read/write port of each ring memory, used once per command.
// When the receiver stalls, one result waits in the output register and one
// more in the pending stage; the input then stalls until the output moves.
// Reset clears pointers, counts, sticky flags and the send state; the ring
// memories are not cleared, an entry is only read after it has been written.
// Line errors are ORed into sticky flags; a received byte into a full ring
// sets the buffer-full flag. A send burst is accepted or rejected as a whole
// on its first byte and committed at its last byte.
module uart_buffered_rx_tx_queues #(
  parameter int unsigned RX_DEPTH = ubrtq_pkg::RxDepthDef,
  parameter int unsigned TX_DEPTH = ubrtq_pkg::TxDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ubrtq_pkg::CmdW-1:0]  command_i,
  input  logic [ubrtq_pkg::ByteW-1:0] data_byte_i,
  input  logic                        byte_present_i,
  input  logic [ubrtq_pkg::ErrW-1:0]  line_errors_i,
  input  logic [ubrtq_pkg::LenW-1:0]  send_length_i,
  input  logic                        burst_last_i,
  input  logic [ubrtq_pkg::MaskW-1:0] clear_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ubrtq_pkg::ByteW-1:0] rx_data_o,
  output logic                        rx_valid_o,
  output logic [ubrtq_pkg::ByteW-1:0] tx_data_o,
  output logic                        tx_valid_o,
  output logic                        accepted_o,
  output logic                        busy_flag_o,
  output logic                        done_pulse_o,
  output logic [ubrtq_pkg::FillW-1:0] rx_fill_o,
  output logic [ubrtq_pkg::FlagW-1:0] sticky_flags_o
);
  import ubrtq_pkg::*;

  localparam int unsigned RxAw  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned RxCw  = $clog2(RX_DEPTH + 1);
  localparam int unsigned TxAw  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned TxCw  = $clog2(TX_DEPTH + 1);
  localparam int unsigned TxSw  = TxCw + 1;
  localparam int unsigned LcW   = (TxCw > LenW) ? TxCw : LenW;
  localparam int unsigned RfW   = (RxCw > FillW) ? RxCw : FillW;

  localparam logic [RxAw-1:0] RxLast  = RxAw'(RX_DEPTH - 1);
  localparam logic [RxCw-1:0] RxFull  = RxCw'(RX_DEPTH);
  localparam logic [TxAw-1:0] TxLast  = TxAw'(TX_DEPTH - 1);
  localparam logic [TxCw-1:0] TxFull  = TxCw'(TX_DEPTH);
  localparam logic [TxSw-1:0] TxWrap  = TxSw'(TX_DEPTH);

  // Ring memories and their registered read data
  logic [ByteW-1:0] rx_mem_q [RX_DEPTH];
  logic [ByteW-1:0] tx_mem_q [TX_DEPTH];
  logic [ByteW-1:0] rx_rd_q, tx_rd_q;

  // Control state
  logic [RxAw-1:0]  rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RxCw-1:0]  rx_count_q, rx_count_d;
  logic [TxAw-1:0]  tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TxCw-1:0]  tx_count_q, tx_count_d;
  logic [TxCw-1:0]  burst_wr_q, burst_wr_d;
  burst_e           burst_q, burst_d;
  logic             busy_q, busy_d;
  logic             rdy_en_q, rdy_en_d;
  logic             cmpl_en_q, cmpl_en_d;
  logic [FlagW-1:0] flags_q, flags_d;

  // Handshake and result pipeline
  logic             pend_valid_q, pend_valid_d;
  logic             out_valid_q, out_valid_d;
  res_t             pend_q, res_d, out_q;
  logic [ByteW-1:0] out_rx_q, out_tx_q;
  logic             in_accept, pend_move;

  // Memory controls
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [TxAw-1:0]  tx_wa;

  // Scratch values for the step
  cmd_e             cmd;
  logic [TxCw-1:0]  tx_free;
  logic [TxSw-1:0]  tx_sum;
  logic [RfW-1:0]   fill_ext;

  assign pend_move  = pend_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_valid_q && !pend_move;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(command_i);

  // Work out the next state and the result of the command
  always_comb begin
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    rx_count_d = rx_count_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    tx_count_d = tx_count_q;
    burst_wr_d = burst_wr_q;
    burst_d    = burst_q;
    busy_d     = busy_q;
    rdy_en_d   = rdy_en_q;
    cmpl_en_d  = cmpl_en_q;
    flags_d    = flags_q;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    tx_wa      = tx_tail_q;
    tx_free    = TxFull - tx_count_q;
    tx_sum     = '0;
    res_d      = '0;

    case (cmd)
      CMD_LINE_BYTE: begin
        if (byte_present_i) begin
          if (rx_count_q != RxFull) begin
            rx_we      = 1'b1;
            rx_tail_d  = (rx_tail_q == RxLast) ? '0 : rx_tail_q + 1'b1;
            rx_count_d = rx_count_q + 1'b1;
          end else begin
            flags_d[FlagBufFull] = 1'b1;
          end
        end
        flags_d = flags_d | FlagW'(line_errors_i);
      end
      CMD_APP_READ: begin
        if (rx_count_q != '0) begin
          rx_re          = 1'b1;
          res_d.rx_valid = 1'b1;
          rx_head_d      = (rx_head_q == RxLast) ? '0 : rx_head_q + 1'b1;
          rx_count_d     = rx_count_q - 1'b1;
        end
      end
      CMD_SEND_BYTE: begin
        // Decide the fate of a burst on its first byte
        if (burst_q == BS_IDLE) begin
          burst_wr_d = '0;
          if (send_length_i == '0) begin
            burst_d = BS_SKIP;
          end else if (busy_q || (LcW'(tx_free) < LcW'(send_length_i))) begin
            burst_d = BS_REJECT;
          end else begin
            burst_d  = BS_FILL;
            rdy_en_d = 1'b0;
          end
        end
        if (burst_d == BS_FILL) begin
          res_d.accepted = 1'b1;
          // Stage the byte while there is room
          if (burst_wr_d < tx_free) begin
            tx_sum     = TxSw'(tx_tail_q) + TxSw'(burst_wr_d);
            tx_sum     = (tx_sum >= TxWrap) ? tx_sum - TxWrap : tx_sum;
            tx_wa      = tx_sum[TxAw-1:0];
            tx_we      = 1'b1;
            burst_wr_d = burst_wr_d + 1'b1;
          end
          // Commit the staged bytes at the end of the burst
          if (burst_last_i) begin
            tx_sum     = TxSw'(tx_tail_q) + TxSw'(burst_wr_d);
            tx_sum     = (tx_sum >= TxWrap) ? tx_sum - TxWrap : tx_sum;
            tx_tail_d  = tx_sum[TxAw-1:0];
            tx_count_d = tx_count_q + burst_wr_d;
            burst_wr_d = '0;
            busy_d     = 1'b1;
            rdy_en_d   = 1'b1;
            burst_d    = BS_IDLE;
          end
        end else begin
          res_d.accepted = (burst_d == BS_SKIP);
          if (burst_last_i) begin
            burst_d = BS_IDLE;
          end
        end
      end
      CMD_TX_READY: begin
        if (rdy_en_q && (tx_count_q != '0)) begin
          tx_re          = 1'b1;
          res_d.tx_valid = 1'b1;
          tx_head_d      = (tx_head_q == TxLast) ? '0 : tx_head_q + 1'b1;
          tx_count_d     = tx_count_q - 1'b1;
          if (tx_count_d == '0) begin
            rdy_en_d  = 1'b0;
            cmpl_en_d = 1'b1;
          end
        end
      end
      CMD_TX_DONE: begin
        if (cmpl_en_q) begin
          cmpl_en_d  = 1'b0;
          busy_d     = 1'b0;
          res_d.done = 1'b1;
        end
      end
      CMD_CLEAR: begin
        flags_d = flags_q & ~clear_mask_i;
      end
      default: begin
      end
    endcase

    fill_ext    = RfW'(rx_count_d);
    res_d.fill  = fill_ext[FillW-1:0];
    res_d.busy  = busy_d;
    res_d.flags = flags_d;
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q    <= '0;
      rx_tail_q    <= '0;
      rx_count_q   <= '0;
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      tx_count_q   <= '0;
      burst_wr_q   <= '0;
      burst_q      <= BS_IDLE;
      busy_q       <= 1'b0;
      rdy_en_q     <= 1'b0;
      cmpl_en_q    <= 1'b0;
      flags_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        rx_head_q  <= rx_head_d;
        rx_tail_q  <= rx_tail_d;
        rx_count_q <= rx_count_d;
        tx_head_q  <= tx_head_d;
        tx_tail_q  <= tx_tail_d;
        tx_count_q <= tx_count_d;
        burst_wr_q <= burst_wr_d;
        burst_q    <= burst_d;
        busy_q     <= busy_d;
        rdy_en_q   <= rdy_en_d;
        cmpl_en_q  <= cmpl_en_d;
        flags_q    <= flags_d;
      end
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Advance the pending and output stages
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (in_accept) begin
      pend_valid_d = 1'b1;
    end else if (pend_move) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_q <= res_d;
    end
    if (pend_move) begin
      out_q    <= pend_q;
      out_rx_q <= pend_q.rx_valid ? rx_rd_q : '0;
      out_tx_q <= pend_q.tx_valid ? tx_rd_q : '0;
    end
  end

  // Receive ring: one write or one read per transaction
  always_ff @(posedge clk_i) begin
    if (in_accept && rx_we) begin
      rx_mem_q[rx_tail_q] <= data_byte_i;
    end
    if (in_accept && rx_re) begin
      rx_rd_q <= rx_mem_q[rx_head_q];
    end
  end

  // Transmit ring: one write or one read per transaction
  always_ff @(posedge clk_i) begin
    if (in_accept && tx_we) begin
      tx_mem_q[tx_wa] <= data_byte_i;
    end
    if (in_accept && tx_re) begin
      tx_rd_q <= tx_mem_q[tx_head_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rx_data_o      = out_rx_q;
  assign rx_valid_o     = out_q.rx_valid;
  assign tx_data_o      = out_tx_q;
  assign tx_valid_o     = out_q.tx_valid;
  assign accepted_o     = out_q.accepted;
  assign busy_flag_o    = out_q.busy;
  assign done_pulse_o   = out_q.done;
  assign rx_fill_o      = out_q.fill;
  assign sticky_flags_o = out_q.flags;

endmodule
